>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultCapacity = 16;

  localparam int unsigned TagW   = 32;
  localparam int unsigned KindW  = 8;
  localparam int unsigned PrioW  = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic [KindW-1:0]        kind;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // Flags that one cell reports about the entry it holds.
  typedef struct packed {
    logic le;     // holds a valid entry that sorts at or before the new one
    logic match;  // holds a valid entry with the requested tag
  } cell_flags_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADTAG = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

endpackage

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its entry with the request and
// keeps it, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                   clk_i,
  input  logic                   valid_i,
  input  spq_pkg::cell_cmd_e     cmd_i,
  input  spq_pkg::entry_t        new_i,
  input  spq_pkg::entry_t        prev_i,
  input  logic                   prev_le_i,
  input  spq_pkg::entry_t        next_i,
  output spq_pkg::entry_t        entry_o,
  output spq_pkg::cell_flags_t   flags_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  assign flags_o.le    = valid_i && (entry_q.prio <= new_i.prio);
  assign flags_o.match = valid_i && (entry_q.tag == new_i.tag);
  assign entry_o       = entry_q;

  // Sorted order makes the le flags a run of ones from the head, so the
  // first cell without le is the insert point and the rest shift down.
  always_comb begin
    entry_d = entry_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (!flags_o.le) begin
          entry_d = prev_le_i ? new_i : prev_i;
        end
      end
      CMD_REMOVE: entry_d = next_i;
      CMD_HOLD:   entry_d = entry_q;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> sv/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue held sorted in a chain of cells, FIFO among ties.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred on the rising edge where start_i is high and
//   busy_o is low. op_i selects insert (with item_tag_i, kind_i and
//   priority_req_i) or removal of the head entry.
//   The edge after the transfer, every cell compares its entry with the
//   request in parallel and the whole chain shifts at once; busy_o is high
//   for that one cycle. The result appears the cycle after that, on
//   status_o, count_o and out_*_o, marked by done_o for exactly one cycle.
//   A new command cannot be transferred while busy_o is high, since the
//   compare and shift over the cell chain has to finish before it.
//   The receiver cannot stall: the result must be taken in its cycle, and
//   a new command may be transferred in the same cycle that done_o is high.
//   Reset empties the queue (count zero) and clears busy_o and done_o; the
//   entry storage itself is not cleared, since only occupied cells are read.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            op_i,
  input  logic [spq_pkg::TagW-1:0]        item_tag_i,
  input  logic [spq_pkg::KindW-1:0]       kind_i,
  input  logic signed [spq_pkg::PrioW-1:0] priority_req_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [spq_pkg::CountW-1:0]      count_o,
  output logic [spq_pkg::TagW-1:0]        out_tag_o,
  output logic [spq_pkg::KindW-1:0]       out_kind_o,
  output logic signed [spq_pkg::PrioW-1:0] out_priority_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            busy_q;
  logic            done_q;
  op_e             req_op_q;
  entry_t          req_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  status_e         status_q;
  status_e         status_d;
  entry_t          out_q;
  entry_t          out_d;
  cell_cmd_e       cmd;

  entry_t          cell_entry [CAPACITY];
  cell_flags_t     cell_flags [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic            dup;
  logic            full;
  logic            accept;

  assign accept = start_i && !busy_q;

  // Request register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_op_q   <= op_e'(op_i);
      req_q.tag  <= item_tag_i;
      req_q.kind <= kind_i;
      req_q.prio <= priority_req_i;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t prev_entry;
      entry_t next_entry;
      logic   prev_le;
      logic   valid;

      assign valid = count_q > CntW'(gi);
      assign match_vec[gi] = cell_flags[gi].match;

      if (gi == 0) begin : g_head
        assign prev_entry = req_q;
        assign prev_le    = 1'b0;
      end else begin : g_body
        assign prev_entry = cell_entry[gi-1];
        assign prev_le    = cell_flags[gi-1].le;
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign next_entry = cell_entry[gi];
      end else begin : g_inner
        assign next_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk_i     (clk_i),
        .valid_i   (valid),
        .cmd_i     (cmd),
        .new_i     (req_q),
        .prev_i    (prev_entry),
        .prev_le_i (prev_le),
        .next_i    (next_entry),
        .entry_o   (cell_entry[gi]),
        .flags_o   (cell_flags[gi])
      );
    end
  endgenerate

  assign dup  = |match_vec;
  assign full = count_q == CntW'(CAPACITY);

  always_comb begin
    cmd      = CMD_HOLD;
    count_d  = count_q;
    status_d = ST_OK;
    out_d    = '0;
    if (busy_q) begin
      if (req_op_q == OP_INSERT) begin
        if (req_q.tag == '0 || dup) begin
          status_d = ST_BADTAG;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd     = CMD_INSERT;
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cmd     = CMD_REMOVE;
          count_d = count_q - CntW'(1);
          out_d   = cell_entry[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= accept;
      done_q  <= busy_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      out_q    <= out_d;
    end
  end

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign count_o        = CountW'(count_q);
  assign out_tag_o      = out_q.tag;
  assign out_kind_o     = out_q.kind;
  assign out_priority_o = out_q.prio;

  // Each accepted command is worked while busy_o is high, followed by its result.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o did not follow an accepted command");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q))
    else $error("result strobe without a command in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (count_q == '0 && out_tag_o == '0))
    else $error("empty status with entries present");

endmodule

>>> bench/spq_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_monitor
// Watches the command and result channels of the sorted priority queue,
// keeps its own sorted copy of the queue contents, works out the result of
// every command transfer and compares each result transfer with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module spq_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic                             op_i,
  input  logic [spq_pkg::TagW-1:0]         item_tag_i,
  input  logic [spq_pkg::KindW-1:0]        kind_i,
  input  logic signed [spq_pkg::PrioW-1:0] priority_req_i,
  input  logic                             done_i,
  input  logic [1:0]                       status_i,
  input  logic [spq_pkg::CountW-1:0]       count_i,
  input  logic [spq_pkg::TagW-1:0]         out_tag_i,
  input  logic [spq_pkg::KindW-1:0]        out_kind_i,
  input  logic signed [spq_pkg::PrioW-1:0] out_priority_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import spq_pkg::*;

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    status_e                 status;
    logic [CountW-1:0]       count;
    logic [TagW-1:0]         tag;
    logic [KindW-1:0]        kind;
    logic signed [PrioW-1:0] prio;
  } queue_result_t;

  // Entries held in the queue, head first.
  entry_t        sorted_entries[$];
  queue_result_t expected_results[$];
  queue_result_t observed;
  queue_result_t oldest;
  int            failures;

  // Applies one command to the local copy of the queue and returns its result.
  function automatic queue_result_t apply_queue_op(input op_e op,
                                                   input logic [TagW-1:0] tag,
                                                   input logic [KindW-1:0] kind,
                                                   input logic signed [PrioW-1:0] prio);
    queue_result_t res;
    entry_t        fresh;
    int            pos;
    logic          present;
    res     = '{status: ST_OK, count: '0, tag: '0, kind: '0, prio: '0};
    present = 1'b0;
    if (op == OP_INSERT) begin
      foreach (sorted_entries[i]) begin
        if (sorted_entries[i].tag == tag) present = 1'b1;
      end
      if (tag == '0 || present) begin
        res.status = ST_BADTAG;
      end else if (sorted_entries.size() >= DefaultCapacity) begin
        res.status = ST_FULL;
      end else begin
        // Equal priorities go behind the ones already stored, so ties stay FIFO.
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio) pos++;
        fresh = '{tag: tag, kind: kind, prio: prio};
        sorted_entries.insert(pos, fresh);
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.tag  = sorted_entries[0].tag;
        res.kind = sorted_entries[0].kind;
        res.prio = sorted_entries[0].prio;
        void'(sorted_entries.pop_front());
      end
    end
    res.count = CountW'(sorted_entries.size());
    return res;
  endfunction

  task automatic report_failure(input string what, input queue_result_t exp,
                                input queue_result_t got);
    failures++;
    if (failures <= MaxReports) begin
      $display("%0t: %s: expected status=%0d count=%0d tag=%h kind=%h prio=%0d",
               $realtime, what, exp.status, exp.count, exp.tag, exp.kind, exp.prio);
      $display("%0t: %s:   actual status=%0d count=%0d tag=%h kind=%h prio=%0d",
               $realtime, what, got.status, got.count, got.tag, got.kind, got.prio);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_entries.delete();
      expected_results.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // The result transfer belongs to an older command, so it is checked
      // before a command transferred at the same edge is predicted.
      if (done_i) begin
        observed = '{status: status_e'(status_i), count: count_i, tag: out_tag_i,
                     kind: out_kind_i, prio: out_priority_i};
        if (expected_results.size() == 0) begin
          report_failure("unexpected result", '0, observed);
        end else begin
          oldest = expected_results.pop_front();
          if (observed !== oldest) report_failure("result mismatch", oldest, observed);
        end
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(apply_queue_op(op_e'(op_i), item_tag_i, kind_i,
                                                  priority_req_i));
      end
      fail_count_o <= failures;
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> bench/stable_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_test
// Drives directed and random insert and remove commands into the sorted
// priority queue with random idle gaps, and leaves checking to spq_monitor.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned RandomItems = 1425;
  localparam int unsigned StallLimit  = 500;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    op_i = OP_INSERT;
  logic [TagW-1:0]         item_tag_i = '0;
  logic [KindW-1:0]        kind_i = '0;
  logic signed [PrioW-1:0] priority_req_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [CountW-1:0]       count_o;
  logic [TagW-1:0]         out_tag_o;
  logic [KindW-1:0]        out_kind_o;
  logic signed [PrioW-1:0] out_priority_o;
  int                      fail_count;
  int                      pending;
  int unsigned             stall_cycles = 0;

  always #6 clk_i = ~clk_i;

  stable_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .item_tag_i     (item_tag_i),
    .kind_i         (kind_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .out_tag_o      (out_tag_o),
    .out_kind_o     (out_kind_o),
    .out_priority_o (out_priority_o)
  );

  spq_monitor monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .op_i           (op_i),
    .item_tag_i     (item_tag_i),
    .kind_i         (kind_i),
    .priority_req_i (priority_req_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .count_i        (count_o),
    .out_tag_i      (out_tag_o),
    .out_kind_i     (out_kind_o),
    .out_priority_i (out_priority_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Called right after a rising edge; returns at the edge of the transfer.
  // start_i is left high so that a following command can go back to back.
  task automatic send_command(input op_e op, input logic [TagW-1:0] tag,
                              input logic [KindW-1:0] kind,
                              input logic signed [PrioW-1:0] prio);
    start_i <= 1'b1;
    op_i <= op;
    item_tag_i <= tag;
    kind_i <= kind;
    priority_req_i <= prio;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    start_i <= 1'b0;
    op_i <= 1'($urandom_range(0, 1));
    item_tag_i <= $urandom;
    kind_i <= KindW'($urandom);
    priority_req_i <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every outstanding command has returned its result.
  task automatic drain_results;
    idle_sender(1);
    while (pending != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
        $display("FAIL stable_priority_queue");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned             r;
    int unsigned             insert_pct;
    int unsigned             gap;
    logic                    no_idle;
    logic [TagW-1:0]         tag;
    logic signed [PrioW-1:0] prio;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty removal, null and duplicate tags, extreme fields,
    // ties, a full queue and a duplicate checked ahead of the full check.
    send_command(OP_REMOVE, $urandom, KindW'($urandom), $urandom);
    send_command(OP_INSERT, '0, 8'h5A, 32'sd7);
    send_command(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'sh7FFF_FFFF);
    send_command(OP_INSERT, 32'h0000_0001, 8'h00, 32'sh8000_0000);
    send_command(OP_INSERT, 32'h0000_0001, 8'h11, 32'sd0);
    send_command(OP_INSERT, 32'h0000_0002, 8'h22, 32'sd0);
    send_command(OP_INSERT, 32'h0000_0003, 8'h33, 32'sd0);
    for (int i = 0; i < 12; i++) begin
      send_command(OP_INSERT, 100 + i, 8'(i), (i % 3) - 1);
    end
    send_command(OP_INSERT, 32'h0000_0200, 8'h44, 32'sd5);
    send_command(OP_INSERT, 32'h0000_0002, 8'h55, 32'sd5);
    send_command(OP_INSERT, '0, 8'h66, 32'sd5);
    repeat (3) send_command(OP_REMOVE, $urandom, KindW'($urandom), $urandom);

    insert_pct = 50;
    no_idle = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      // Alternate filling, draining and mixed phases so that the queue
      // reaches both full and empty many times.
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 300 == 150) drain_results();

      r = $urandom_range(0, 99);
      if (r < 5) tag = '0;
      else if (r < 60) tag = $urandom_range(1, 48);
      else tag = $urandom;

      r = $urandom_range(0, 99);
      if (r < 40) prio = $urandom_range(0, 6) - 3;
      else if (r < 50) begin
        case ($urandom_range(0, 3))
          0: prio = 32'sh8000_0000;
          1: prio = 32'sh7FFF_FFFF;
          2: prio = -32'sd1;
          default: prio = 32'sd0;
        endcase
      end else prio = $urandom;

      if ($urandom_range(0, 99) < insert_pct) begin
        send_command(OP_INSERT, tag, KindW'($urandom), prio);
      end else begin
        send_command(OP_REMOVE, tag, KindW'($urandom), prio);
      end

      if (!no_idle) begin
        r = $urandom_range(0, 99);
        if (r < 50) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 40);
        if (gap != 0) idle_sender(gap);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

endmodule

>>> files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
bench/spq_monitor.sv
bench/stable_priority_queue_test.sv
